/* rtl/trld_pkg.sv */
package trld_pkg;

  // Reset value of the per-stream tile cap
  localparam logic [15:0] MaxTilesReset = 16'd12000;

  // Default depth of the command queue between front and back
  localparam int unsigned QueueDepthDefault = 4;

  // Word that ends a stream
  localparam logic [15:0] EndWord = 16'hFFFF;

  // Command kinds handed from front to back
  localparam logic [1:0] KindNone = 2'd0;  // low byte held, nothing to run
  localparam logic [1:0] KindRun  = 2'd1;  // tile run
  localparam logic [1:0] KindTerm = 2'd2;  // terminator word

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] tile_id;
    logic [3:0] rep_m1;   // repeat count minus one
    logic       last;     // byte was marked last
  } cmd_t;

endpackage

/* rtl/trld_in_if.sv */
interface trld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;

  modport source(output valid, output data_byte, output is_last, input ready);
  modport sink(input valid, input data_byte, input is_last, output ready);
endinterface

/* rtl/trld_out_if.sv */
interface trld_out_if;
  logic        valid;
  logic        ready;
  logic [9:0]  tile_id;
  logic        is_end;
  logic [15:0] tile_count;
  logic        last_of_run;

  modport source(output valid, output tile_id, output is_end, output tile_count,
                 output last_of_run, input ready);
  modport sink(input valid, input tile_id, input is_end, input tile_count,
               input last_of_run, output ready);
endinterface

/* rtl/trld_front.sv */
module trld_front import trld_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  trld_in_if.sink  in_items,
  output cmd_t     cmd,
  output logic     cmd_valid,
  input  logic     cmd_ready
);

  logic [7:0]  hold;
  logic        have;
  logic [15:0] word;
  logic        accept;

  assign accept = in_items.valid && cmd_ready;
  assign word   = {in_items.data_byte, hold};

  // One command per byte; the back side applies the cap check on every byte
  always_comb begin
    cmd.kind    = KindNone;
    cmd.tile_id = word[9:0];
    cmd.rep_m1  = word[13:10];
    cmd.last    = in_items.is_last;
    if (have) begin
      cmd.kind = (word == EndWord) ? KindTerm : KindRun;
    end
  end

  assign cmd_valid      = in_items.valid;
  assign in_items.ready = cmd_ready;

  // Byte pairing, low byte first; an unpaired last byte is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (accept) begin
      if (in_items.is_last) begin
        have <= 1'b0;
      end else begin
        have <= !have;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !have) begin
      hold <= in_items.data_byte;
    end
  end

endmodule

/* rtl/trld_cmd_queue.sv */
module trld_cmd_queue import trld_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t push_cmd,
  input  logic push_valid,
  output logic push_ready,
  output cmd_t pop_cmd,
  output logic pop_valid,
  input  logic pop_ready
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CntW'(Depth));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* rtl/trld_back.sv */
module trld_back import trld_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] tile_cap,
  input  cmd_t        cmd,
  input  logic        cmd_valid,
  output logic        cmd_ready,
  trld_out_if.source  out_items
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StEnd  = 2'd2;

  logic [1:0]  state;
  logic        stopped;
  logic [15:0] tiles;
  logic [9:0]  cur_id;
  logic [3:0]  cnt;
  logic        cur_last;

  logic        o_valid;
  logic [9:0]  o_tile_id;
  logic        o_is_end;
  logic [15:0] o_count;
  logic        o_last;

  logic        out_free;
  logic        stop_now;
  logic [15:0] tiles_inc;
  logic        cap_hit;
  logic        run_done;

  assign out_free  = !o_valid || out_items.ready;
  assign cmd_ready = (state == StIdle);
  assign stop_now  = stopped || (tiles >= tile_cap);
  assign tiles_inc = tiles + 16'd1;
  assign cap_hit   = (tiles_inc >= tile_cap);
  assign run_done  = (cnt == 4'd0) || cap_hit;

  assign out_items.valid       = o_valid;
  assign out_items.tile_id     = o_tile_id;
  assign out_items.is_end      = o_is_end;
  assign out_items.tile_count  = o_count;
  assign out_items.last_of_run = o_last;

  // Sequencer: take a command, expand its run, then the end item after a last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= StIdle;
      stopped <= 1'b0;
      tiles   <= '0;
      o_valid <= 1'b0;
    end else begin
      if (o_valid && out_items.ready) begin
        o_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (cmd_valid) begin
            stopped <= stop_now || (cmd.kind == KindTerm);
            if (!stop_now && cmd.kind == KindRun) begin
              state <= StRun;
            end else if (cmd.last) begin
              state <= StEnd;
            end
          end
        end
        StRun: begin
          if (out_free) begin
            o_valid <= 1'b1;
            tiles   <= tiles_inc;
            if (run_done) begin
              if (cap_hit) begin
                stopped <= 1'b1;
              end
              state <= cur_last ? StEnd : StIdle;
            end
          end
        end
        StEnd: begin
          if (out_free) begin
            o_valid <= 1'b1;
            tiles   <= '0;
            stopped <= 1'b0;
            state   <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  // Current command and result payload
  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        if (cmd_valid) begin
          cur_id   <= cmd.tile_id;
          cnt      <= cmd.rep_m1;
          cur_last <= cmd.last;
        end
      end
      StRun: begin
        if (out_free) begin
          o_tile_id <= cur_id;
          o_is_end  <= 1'b0;
          o_count   <= tiles_inc;
          o_last    <= run_done && !cur_last;
          cnt       <= cnt - 4'd1;
        end
      end
      StEnd: begin
        if (out_free) begin
          o_tile_id <= '0;
          o_is_end  <= 1'b1;
          o_count   <= tiles;
          o_last    <= 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/tile_run_length_decoder.sv */
// Channel    | Dir | Payload                                        | Handshake
// in_items   | in  | data_byte[7:0], is_last                        | valid/ready
// out_items  | out | tile_id[9:0], is_end, tile_count[15:0],        | valid/ready
//            |     | last_of_run                                    |
// cfg        | in  | cfg_wdata[15:0] -> tile cap                    | cfg_we
//
// Each byte turns into one command in a small queue; the back sequencer takes
// one command at a time, then emits its tiles (up to 16) and, after a last
// byte, the end item, waiting on the single result port while it is full.
// Synchronous reset clears the pairing state, queue, counters and sets
// the tile cap to 12000. The front keeps taking bytes while the queue has room,
// and the output register frees the back side whenever the result is taken.
module tile_run_length_decoder import trld_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  trld_in_if.sink     in_items,
  trld_out_if.source  out_items
);

  logic [15:0] tile_cap;
  cmd_t        f_cmd;
  logic        f_valid;
  logic        f_ready;
  cmd_t        b_cmd;
  logic        b_valid;
  logic        b_ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      tile_cap <= MaxTilesReset;
    end else if (cfg_we) begin
      tile_cap <= cfg_wdata;
    end
  end

  trld_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_items  (in_items),
    .cmd       (f_cmd),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready)
  );

  trld_cmd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_cmd   (f_cmd),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .pop_cmd    (b_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready)
  );

  trld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tile_cap  (tile_cap),
    .cmd       (b_cmd),
    .cmd_valid (b_valid),
    .cmd_ready (b_ready),
    .out_items (out_items)
  );

endmodule
